### hdl/lmss_pkg.sv
// Shared types, register codes and constants for the LED matrix scan/scroll block.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package lmss_pkg;

  localparam int unsigned OUT_W     = 8;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned SCROLL_W  = 17;
  localparam int unsigned SW_W      = 2;
  localparam int unsigned RIDX_W    = 3;

  localparam logic [CFG_W-1:0] SCROLL_PERIOD_RST  = 16'd20000;
  localparam logic [CFG_W-1:0] DEBOUNCE_TICKS_RST = 16'd200;

  typedef enum logic {
    CMD_TICK      = 1'b0,
    CMD_ROW_WRITE = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_SCROLL_PERIOD  = 1'b0,
    REG_DEBOUNCE_TICKS = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    cmd_e              command;
    logic [SW_W-1:0]   switch_pressed;
    logic [RIDX_W-1:0] row_index;
    logic [OUT_W-1:0]  row_bits;
  } item_t;

  typedef struct packed {
    logic [OUT_W-1:0] column_select;
    logic [OUT_W-1:0] row_drive;
    logic [SW_W-1:0]  scroll_mode;
    logic             change_seen;
  } result_t;

  // debounced switch state after the current item
  typedef struct packed {
    logic [SW_W-1:0] stable;
    logic            change;
  } dbn_status_t;

  // what the frame/scan unit does this cycle
  typedef struct packed {
    logic tick;
    logic write;
  } step_t;

  // digit-one glyph, row 0 first
  localparam logic [7:0] GLYPH_ONE [8] = '{
    8'h18, 8'h38, 8'h78, 8'h18, 8'h18, 8'h18, 8'h18, 8'h7E
  };

  function automatic logic [7:0] glyph_row(int unsigned idx);
    logic [2:0] sel;
    sel = idx[2:0];
    if (idx < 8) begin
      return GLYPH_ONE[sel];
    end
    return 8'h00;
  endfunction

endpackage

`default_nettype wire

### hdl/lmss_item_if.sv
// Input channel: valid/ready handshake carrying one command item.
// Depends on lmss_pkg for the item type.
`default_nettype none

interface lmss_item_if;
  logic           valid;
  logic           ready;
  lmss_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/lmss_result_if.sv
// Result channel: valid/ready handshake carrying one scan result.
// Depends on lmss_pkg for the result type.
`default_nettype none

interface lmss_result_if;
  logic             valid;
  logic             ready;
  lmss_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/lmss_cfg_if.sv
// Configuration write channel: register index and write data under valid/ready.
// Depends on lmss_pkg for the register code type.
`default_nettype none

interface lmss_cfg_if;
  logic                           valid;
  logic                           ready;
  lmss_pkg::cfg_reg_e             index;
  logic [lmss_pkg::CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/lmss_debounce.sv
// Two-bit switch debouncer with sticky change flag.
// Depends on lmss_pkg.
`default_nettype none

module lmss_debounce (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          tick_i,
  input  wire logic [lmss_pkg::SW_W-1:0]     sample_i,
  input  wire logic [lmss_pkg::CFG_W-1:0]    debounce_ticks_i,
  output lmss_pkg::dbn_status_t              status_o
);
  import lmss_pkg::*;

  logic              waiting_q, waiting_d;
  logic [CFG_W-1:0]  count_q, count_d;
  logic [SW_W-1:0]   stable_q, stable_d;
  logic              change_q, change_d;
  logic [CFG_W-1:0]  count_dec;

  assign count_dec = count_q - CFG_W'(1);

  always_comb begin
    waiting_d = waiting_q;
    count_d   = count_q;
    stable_d  = stable_q;
    change_d  = change_q;
    if (tick_i) begin
      if (!waiting_q) begin
        if (stable_q != sample_i) begin
          count_d   = debounce_ticks_i;
          waiting_d = 1'b1;
        end
      end else begin
        count_d = count_dec;
        if (count_dec == '0) begin
          // recheck once the wait has run out
          if (stable_q != sample_i) begin
            change_d = 1'b1;
            stable_d = sample_i;
          end
          waiting_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q <= 1'b0;
      count_q   <= '0;
      stable_q  <= '0;
      change_q  <= 1'b0;
    end else begin
      waiting_q <= waiting_d;
      count_q   <= count_d;
      stable_q  <= stable_d;
      change_q  <= change_d;
    end
  end

  assign status_o.stable = stable_d;
  assign status_o.change = change_d;

  a_flag_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(change_q))
    else $error("change flag cleared outside reset");

  a_stable_after_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(stable_q) |-> $past(waiting_q) && change_q)
    else $error("debounced value changed without a completed wait");

endmodule

`default_nettype wire

### hdl/lmss_frame.sv
// Frame store, column ring, row pointer and scroll timer for the LED matrix.
// Depends on lmss_pkg.
`default_nettype none

module lmss_frame #(
  parameter int unsigned MATRIX_SIZE = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lmss_pkg::step_t               step_i,
  input  wire logic [lmss_pkg::RIDX_W-1:0]   row_index_i,
  input  wire logic [lmss_pkg::OUT_W-1:0]    row_bits_i,
  input  wire logic [lmss_pkg::CFG_W-1:0]    scroll_period_i,
  input  wire logic [lmss_pkg::SW_W-1:0]     mode_i,
  output logic      [lmss_pkg::OUT_W-1:0]    column_o,
  output logic      [lmss_pkg::OUT_W-1:0]    row_drive_o
);
  import lmss_pkg::*;

  localparam int unsigned PTR_W  = (MATRIX_SIZE > 1) ? $clog2(MATRIX_SIZE) : 1;
  localparam int unsigned IDX_W  = 5;
  localparam int unsigned WIDE_W = (MATRIX_SIZE > OUT_W) ? MATRIX_SIZE : OUT_W;

  logic [MATRIX_SIZE-1:0] frame_q [MATRIX_SIZE];
  logic [MATRIX_SIZE-1:0] frame_d [MATRIX_SIZE];
  logic [MATRIX_SIZE-1:0] column_q, column_d;
  logic [PTR_W-1:0]       ptr_q, ptr_d, ptr_inc, rd_addr, wr_addr;
  logic [SCROLL_W-1:0]    scroll_q, scroll_d, scroll_inc;
  logic                   scroll_due;
  logic [IDX_W-1:0]       widx_ext, widx_mod;
  logic [MATRIX_SIZE-1:0] wr_row, rd_row, shown;
  logic [WIDE_W-1:0]      column_wide, shown_wide;

  // row_index < 8 < 2 * MATRIX_SIZE, so one subtract reduces it
  assign widx_ext = IDX_W'(row_index_i);
  assign widx_mod = (widx_ext >= IDX_W'(MATRIX_SIZE)) ? widx_ext - IDX_W'(MATRIX_SIZE)
                                                      : widx_ext;
  assign wr_addr  = widx_mod[PTR_W-1:0];
  assign wr_row   = MATRIX_SIZE'(row_bits_i);

  assign ptr_inc  = (ptr_q == PTR_W'(MATRIX_SIZE - 1)) ? '0 : ptr_q + PTR_W'(1);
  assign rd_addr  = step_i.tick ? ptr_inc : ptr_q;
  assign rd_row   = frame_q[rd_addr];
  assign shown    = (step_i.write && (wr_addr == ptr_q)) ? wr_row : rd_row;

  assign scroll_inc = scroll_q + SCROLL_W'(1);
  assign scroll_due = scroll_inc > SCROLL_W'(scroll_period_i);

  always_comb begin
    frame_d  = frame_q;
    column_d = column_q;
    ptr_d    = ptr_q;
    scroll_d = scroll_q;
    if (step_i.write) begin
      frame_d[wr_addr] = wr_row;
    end else if (step_i.tick) begin
      column_d = {column_q[MATRIX_SIZE-2:0], column_q[MATRIX_SIZE-1]};
      ptr_d    = ptr_inc;
      scroll_d = scroll_due ? '0 : scroll_inc;
      if (scroll_due) begin
        for (int i = 0; i < MATRIX_SIZE; i++) begin
          // rows down: last row wraps to the top
          frame_d[i] = mode_i[1] ? frame_q[(i + MATRIX_SIZE - 1) % MATRIX_SIZE]
                                 : frame_q[i];
          if (mode_i[0]) begin
            frame_d[i] = {frame_d[i][0], frame_d[i][MATRIX_SIZE-1:1]};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= ~MATRIX_SIZE'(1);
      ptr_q    <= '0;
      scroll_q <= '0;
      for (int i = 0; i < MATRIX_SIZE; i++) begin
        frame_q[i] <= MATRIX_SIZE'(glyph_row(i));
      end
    end else begin
      column_q <= column_d;
      ptr_q    <= ptr_d;
      scroll_q <= scroll_d;
      frame_q  <= frame_d;
    end
  end

  assign column_wide = WIDE_W'(column_d);
  assign shown_wide  = WIDE_W'(shown);
  assign column_o    = column_wide[OUT_W-1:0];
  assign row_drive_o = shown_wide[OUT_W-1:0];

  // the cold column always tracks the row pointer
  a_ring_tracks_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ~column_q == (MATRIX_SIZE'(1) << ptr_q))
    else $error("column ring and row pointer out of step");

endmodule

`default_nettype wire

### hdl/led_matrix_scan_scroll.sv
// LED matrix scanner with frame scrolling and switch debouncing, top level.
// Channels: in_i (sink) takes items; out_o (source) gives one result per item;
//   cfg_i writes scroll_period (index 0) and debounce_ticks (index 1), always ready.
// An item is a display tick (command 0) with a two-bit switch sample, or a
//   frame row write (command 1) of row_bits into row row_index.
// Each transfer on in_i gives exactly one transfer on out_o, in order.
// Pipeline: an item is registered in the input register on entry, worked
//   once the result register is free, and its result registered there.
// Throughput: one item per cycle unless out_o stalls; the input and result
//   registers form a two-entry pipe, so a new item is taken while a result waits.
// Stall: while out_o is held, the result register holds and the input
//   register fills; in_i.ready then drops until out_o moves.
// Reset (rst_ni low, asynchronous): pipe empty, frame = digit-one glyph,
//   column select 0xFE, row pointer 0, debounce idle, registers at their
//   defaults of 20000 and 200.
// Depends on lmss_pkg, the channel interfaces, lmss_debounce and lmss_frame.
`default_nettype none

module led_matrix_scan_scroll #(
  parameter int unsigned MATRIX_SIZE = 8
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  lmss_item_if.sink     in_i,
  lmss_result_if.source out_o,
  lmss_cfg_if.sink      cfg_i
);
  import lmss_pkg::*;

  logic             in_valid_q;
  item_t            in_q;
  logic             out_valid_q;
  result_t          out_q, result_d;
  logic             out_free, fire;
  logic [CFG_W-1:0] scroll_period_q, debounce_ticks_q;
  step_t            step;
  dbn_status_t      dbn;
  logic [OUT_W-1:0] column, row_drive;

  assign out_free   = !out_valid_q || out_o.ready;
  assign fire       = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || out_free;
  assign cfg_i.ready = 1'b1;

  assign step.tick  = fire && (in_q.command == CMD_TICK);
  assign step.write = fire && (in_q.command == CMD_ROW_WRITE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_period_q  <= SCROLL_PERIOD_RST;
      debounce_ticks_q <= DEBOUNCE_TICKS_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_SCROLL_PERIOD:  scroll_period_q  <= cfg_i.data;
        REG_DEBOUNCE_TICKS: debounce_ticks_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
  end

  lmss_debounce u_debounce (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tick_i           (step.tick),
    .sample_i         (in_q.switch_pressed),
    .debounce_ticks_i (debounce_ticks_q),
    .status_o         (dbn)
  );

  lmss_frame #(
    .MATRIX_SIZE (MATRIX_SIZE)
  ) u_frame (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .row_index_i     (in_q.row_index),
    .row_bits_i      (in_q.row_bits),
    .scroll_period_i (scroll_period_q),
    .mode_i          (dbn.stable),
    .column_o        (column),
    .row_drive_o     (row_drive)
  );

  always_comb begin
    result_d.column_select = column;
    result_d.row_drive     = row_drive;
    result_d.scroll_mode   = dbn.stable;
    result_d.change_seen   = dbn.change;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= result_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // an empty result register always lets the input side move
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty result register");

  // a transfer into the result register only follows a held item
  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result produced without an item");

endmodule

`default_nettype wire
